// File: sv/dks_pkg.sv
// Shared constants, types and bit-select functions for the DES key schedule.
// No dependencies; every other file refers to it by scoped names.
package dks_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned HALF_W   = 28;
	localparam int unsigned CD_W     = 56;
	localparam int unsigned SUBKEY_W = 48;
	localparam int unsigned ROUND_W  = 5;
	localparam int unsigned ROUNDS   = 16;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [ROUND_W-1:0] FIRST_ROUND = ROUND_W'(1);
	localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(ROUNDS);

	typedef struct packed {
		logic              vld;
		logic [HALF_W-1:0] c;
		logic [HALF_W-1:0] d;
	} dks_halves_t;

	localparam byte unsigned PC1[CD_W] = '{
		57, 49, 41, 33, 25, 17, 9,
		1,  58, 50, 42, 34, 26, 18,
		10, 2,  59, 51, 43, 35, 27,
		19, 11, 3,  60, 52, 44, 36,
		63, 55, 47, 39, 31, 23, 15,
		7,  62, 54, 46, 38, 30, 22,
		14, 6,  61, 53, 45, 37, 29,
		21, 13, 5,  28, 20, 12, 4
	};

	localparam byte unsigned PC2[SUBKEY_W] = '{
		14, 17, 11, 24, 1,  5,
		3,  28, 15, 6,  21, 10,
		23, 19, 12, 4,  26, 8,
		16, 7,  27, 20, 13, 2,
		41, 52, 31, 37, 47, 55,
		30, 40, 51, 45, 33, 48,
		44, 49, 39, 56, 34, 53,
		46, 42, 50, 36, 29, 32
	};

	// DES numbers bits from 1 at the MSB.
	function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
		logic [CD_W-1:0] res;
		res = '0;
		for (int i = 0; i < CD_W; i++) begin
			res[CD_W-1-i] = key[KEY_W-int'(PC1[i])];
		end
		return res;
	endfunction

	function automatic logic [SUBKEY_W-1:0] pc2(input logic [HALF_W-1:0] c,
		input logic [HALF_W-1:0] d);
		logic [CD_W-1:0]     cd;
		logic [SUBKEY_W-1:0] res;
		cd  = {c, d};
		res = '0;
		for (int i = 0; i < SUBKEY_W; i++) begin
			res[SUBKEY_W-1-i] = cd[CD_W-int'(PC2[i])];
		end
		return res;
	endfunction

	// Rounds 1, 2, 9 and 16 rotate by one, all others by two.
	function automatic logic shift_two(input logic [ROUND_W-1:0] rnd);
		logic two;
		case (rnd) inside
			5'd1, 5'd2, 5'd9, 5'd16: two = 1'b0;
			default:                 two = 1'b1;
		endcase
		return two;
	endfunction

	function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] x,
		input logic two);
		logic [HALF_W-1:0] res;
		if (two) begin
			res = {x[HALF_W-3:0], x[HALF_W-1:HALF_W-2]};
		end else begin
			res = {x[HALF_W-2:0], x[HALF_W-1]};
		end
		return res;
	endfunction

endpackage

// File: sv/dks_front.sv
// Front end: takes key beats and splits them through PC-1 into C and D halves.
// Depends on dks_pkg; feeds dks_queue.
module dks_front (
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dks_pkg::KEY_W-1:0]  key,
	input  logic                       queue_full,
	output dks_pkg::dks_halves_t       push
);

	logic [dks_pkg::CD_W-1:0] cd;

	assign cd       = dks_pkg::pc1(key);
	assign in_stall = queue_full;

	assign push.vld = in_valid & ~queue_full;
	assign push.c   = cd[dks_pkg::CD_W-1:dks_pkg::HALF_W];
	assign push.d   = cd[dks_pkg::HALF_W-1:0];

endmodule

// File: sv/dks_queue.sv
// Short queue of C/D half pairs between the front end and the round engine.
// Depends on dks_pkg.
module dks_queue #(
	parameter int unsigned DEPTH = dks_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dks_pkg::dks_halves_t push,
	input  logic                 pop,
	output dks_pkg::dks_halves_t head,
	output logic                 full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [dks_pkg::HALF_W-1:0] c_mem_q [DEPTH];
	logic [dks_pkg::HALF_W-1:0] d_mem_q [DEPTH];
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [CNT_W-1:0]           count_q;
	logic                       do_pop;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign do_pop = pop & (count_q != '0);

	assign head.vld = (count_q != '0);
	assign head.c   = c_mem_q[rd_ptr_q];
	assign head.d   = d_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.vld) begin
			c_mem_q[wr_ptr_q] <= push.c;
			d_mem_q[wr_ptr_q] <= push.d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.vld) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push.vld, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/dks_back.sv
// Round engine: rotates the halves once per round and registers the PC-2 subkey.
// Depends on dks_pkg; pops dks_queue.
module dks_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dks_pkg::dks_halves_t          head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dks_pkg::SUBKEY_W-1:0]  subkey,
	output logic [dks_pkg::ROUND_W-1:0]   round_number,
	output logic                          last
);

	logic                         busy_q;
	logic [dks_pkg::HALF_W-1:0]   c_q;
	logic [dks_pkg::HALF_W-1:0]   d_q;
	logic [dks_pkg::ROUND_W-1:0]  rnd_q;
	logic                         out_valid_q;
	logic [dks_pkg::SUBKEY_W-1:0] subkey_q;
	logic [dks_pkg::ROUND_W-1:0]  round_q;
	logic                         last_q;

	logic                         advance;
	logic                         fire;
	logic [dks_pkg::ROUND_W-1:0]  rnd;
	logic [dks_pkg::HALF_W-1:0]   c_src;
	logic [dks_pkg::HALF_W-1:0]   d_src;
	logic [dks_pkg::HALF_W-1:0]   c_rot;
	logic [dks_pkg::HALF_W-1:0]   d_rot;
	logic                         two;

	// Output register frees up when empty or when its beat is taken.
	assign advance = ~out_valid_q | ~out_stall;
	assign fire    = advance & (busy_q | head.vld);
	assign pop     = fire & ~busy_q;

	// Between keys, start round 1 straight from the queue head.
	assign rnd   = busy_q ? rnd_q : dks_pkg::FIRST_ROUND;
	assign c_src = busy_q ? c_q : head.c;
	assign d_src = busy_q ? d_q : head.d;
	assign two   = dks_pkg::shift_two(rnd);
	assign c_rot = dks_pkg::rotl28(c_src, two);
	assign d_rot = dks_pkg::rotl28(d_src, two);

	always_ff @(posedge clk) begin
		if (fire) begin
			c_q      <= c_rot;
			d_q      <= d_rot;
			subkey_q <= dks_pkg::pc2(c_rot, d_rot);
			round_q  <= rnd;
			last_q   <= (rnd == dks_pkg::LAST_ROUND);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rnd_q       <= dks_pkg::FIRST_ROUND;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				busy_q      <= (rnd != dks_pkg::LAST_ROUND);
				rnd_q       <= rnd + 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign subkey       = subkey_q;
	assign round_number = round_q;
	assign last         = last_q;

endmodule

// File: sv/des_key_schedule_top.sv
// Top level of the DES key schedule: front end, half queue and round engine.
// Depends on dks_pkg, dks_front, dks_queue and dks_back.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_stall  | key[63:0]
//  output  | out_valid / out_stall| subkey[47:0], round_number[4:0], last
//
// Each key yields 16 subkey beats, one per cycle while out_stall is low, from the single
// round engine, which pops the next key from the queue only after round 16 has been issued.
// The first subkey is computed straight from the queue head and registered when the key is popped.
// Reset clears the queue and engine control; no clearing pass.
// in_stall rises only when the queue is full; out_stall holds the output register.
module des_key_schedule_top #(
	parameter int unsigned QUEUE_DEPTH = dks_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dks_pkg::KEY_W-1:0]     key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dks_pkg::SUBKEY_W-1:0]  subkey,
	output logic [dks_pkg::ROUND_W-1:0]   round_number,
	output logic                          last
);

	dks_pkg::dks_halves_t push;
	dks_pkg::dks_halves_t head;
	logic                 queue_full;
	logic                 pop;

	dks_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key        (key),
		.queue_full (queue_full),
		.push       (push)
	);

	dks_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (queue_full)
	);

	dks_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.subkey       (subkey),
		.round_number (round_number),
		.last         (last)
	);

	a_last_is_round16: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> round_number == dks_pkg::LAST_ROUND)
		else $error("last flag on a round other than 16");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> round_number != '0 && round_number <= dks_pkg::LAST_ROUND)
		else $error("round number out of range");

	a_round_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last ##1 out_valid |->
		round_number == $past(round_number) + 1'b1)
		else $error("subkey rounds not consecutive");

endmodule
